[rtl/page_bitmap_allocator_macros.svh]
// page_bitmap_allocator_macros.svh: assertion macros for the page bitmap allocator
// used by the checker; no other dependencies
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// general property, sampled on the rising clock edge, off while in reset
`define PBA_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("property check failed");

// same-cycle implication
`define PBA_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("implication check failed");

`endif

[rtl/pba_pkg.sv]
// pba_pkg: shared types and codes of the page bitmap allocator
// no dependencies; used by every rtl file of the block but pba_ram and the macros header
package pba_pkg;

    localparam int CELL_BITS  = 32;
    localparam int CELL_SHIFT = 5;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_AREA  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_CLIP  = 2'd3;

    localparam logic [15:0] TOTAL_PAGES_RST = 16'd32768;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [14:0] page_index;
        logic [15:0] page_count;
        logic        area_free;
    } request_t;

    typedef struct packed {
        logic [14:0] alloc_page;
        logic [1:0]  status;
    } result_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_AREA,
        OP_REPORT
    } op_kind_t;

    // classified command as it travels through the queue
    typedef struct packed {
        op_kind_t    kind;
        logic [1:0]  status;
        logic [14:0] first;
        logic [15:0] last;
        logic        make_free;
        logic [15:0] limit;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ALLOC_RD,
        BK_ALLOC_CHK,
        BK_FREE_RD,
        BK_FREE_WR,
        BK_AREA_STEP,
        BK_AREA_WR
    } back_state_t;

endpackage

[rtl/pba_ram.sv]
// pba_ram: generic single-write, single-read ram with registered read data
// no dependencies
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/pba_queue.sv]
// pba_queue: two-entry command queue between front and back
// depends on pba_pkg
module pba_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pba_pkg::op_t       push_op,
    input  logic               pop,
    output pba_pkg::op_t       head_op,
    output pba_pkg::q_status_t q_status
);

    pba_pkg::op_t             entries_reg [pba_pkg::Q_DEPTH];
    logic [pba_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pba_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pba_pkg::Q_AW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op        = entries_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == (pba_pkg::Q_AW + 1)'(pba_pkg::Q_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

[rtl/pba_front.sv]
// pba_front: page total register and command classification
// depends on pba_pkg; feeds pba_queue
module pba_front #(
    parameter int NUM_CELLS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  pba_pkg::request_t request,
    input  logic              cfg_valid,
    input  logic [15:0]       cfg_data,
    output logic              push,
    output pba_pkg::op_t      op
);

    localparam int CAP = NUM_CELLS * pba_pkg::CELL_BITS;

    logic [15:0] total_pages_reg, total_pages_next;
    logic [15:0] limit;
    logic [15:0] start_page;
    logic [15:0] room;
    logic        in_range;
    logic        clipped;
    logic [15:0] count_eff;

    always_comb
    begin
        total_pages_next = total_pages_reg;
        if (cfg_valid)
        begin
            total_pages_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= pba_pkg::TOTAL_PAGES_RST;
        end
        else
        begin
            total_pages_reg <= total_pages_next;
        end
    end

    // page limit: configured total capped at the bitmap size
    assign limit      = (32'(total_pages_reg) < CAP) ? total_pages_reg : 16'(CAP);
    assign start_page = {1'b0, request.page_index};
    assign in_range   = (start_page < limit);
    assign room       = limit - start_page;
    assign clipped    = (request.page_count > room);
    assign count_eff  = clipped ? room : request.page_count;

    always_comb
    begin
        op.kind      = pba_pkg::OP_REPORT;
        op.status    = pba_pkg::ST_DONE;
        op.first     = request.page_index;
        op.last      = start_page + count_eff;
        op.make_free = request.area_free;
        op.limit     = limit;
        unique case (request.cmd)
            pba_pkg::CMD_ALLOC:
            begin
                op.kind = pba_pkg::OP_ALLOC;
            end
            pba_pkg::CMD_FREE:
            begin
                if (in_range)
                begin
                    op.kind = pba_pkg::OP_FREE;
                end
                else
                begin
                    op.status = pba_pkg::ST_RANGE;
                end
            end
            pba_pkg::CMD_AREA:
            begin
                if (!in_range)
                begin
                    op.status = pba_pkg::ST_RANGE;
                end
                else
                begin
                    op.status = clipped ? pba_pkg::ST_CLIP : pba_pkg::ST_DONE;
                    // an empty run only reports
                    if (count_eff != 16'd0)
                    begin
                        op.kind = pba_pkg::OP_AREA;
                    end
                end
            end
            pba_pkg::CMD_NONE:
            begin
                op.kind = pba_pkg::OP_REPORT;
            end
        endcase
    end

    assign push = start && !busy;

endmodule

[rtl/pba_back.sv]
// pba_back: bitmap sequencer that carries out queued commands on the page ram
// depends on pba_pkg and pba_ram
module pba_back #(
    parameter int NUM_CELLS  = 1024,
    parameter int START_CELL = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pba_pkg::op_t      head_op,
    input  logic              empty,
    output logic              pop,
    output logic              clearing,
    output logic              done,
    output pba_pkg::result_t  result
);

    localparam int AW       = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int HINT_MAX = (NUM_CELLS > START_CELL) ? NUM_CELLS : START_CELL;
    localparam int HW       = $clog2(HINT_MAX + 1);

    pba_pkg::back_state_t state_reg, state_next;
    pba_pkg::op_t         op_reg, op_next;
    logic [HW-1:0]        hint_reg, hint_next;
    logic [HW-1:0]        scan_reg, scan_next;
    logic [15:0]          cur_reg, cur_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic                 done_reg, done_next;
    pba_pkg::result_t     result_reg, result_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [11:0]   cells12;
    logic [HW-1:0] cells;
    logic [15:0]   scan_base;
    logic [15:0]   scan_diff;
    logic [31:0]   vmask;
    logic [31:0]   freebits;
    logic [31:0]   low_onehot;
    logic [4:0]    low_idx;
    logic [31:0]   new_cell;
    logic          full_after;

    logic [HW-1:0] free_cell_hw;
    logic [AW-1:0] free_cell;
    logic [31:0]   free_bit;

    logic [AW-1:0] cur_cell;
    logic [4:0]    lo;
    logic [15:0]   rem;
    logic [5:0]    room;
    logic [5:0]    hi;
    logic [31:0]   upper;
    logic [31:0]   lower;
    logic [31:0]   step_mask;
    logic [15:0]   cur_step;

    pba_ram #(
        .WIDTH (32),
        .DEPTH (NUM_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // allocate: cells holding pages below the limit, and the valid bits of one cell
    assign cells12   = 12'(({1'b0, op_reg.limit} + 17'd31) >> pba_pkg::CELL_SHIFT);
    assign cells     = HW'(cells12);
    assign scan_base = 16'({scan_reg, 5'b0});
    assign scan_diff = op_reg.limit - scan_base;
    assign vmask     = (scan_diff >= 16'd32) ? '1 : ((32'd1 << scan_diff[4:0]) - 32'd1);
    assign freebits  = ~ram_rdata & vmask;
    assign low_onehot = freebits & (~freebits + 32'd1);
    assign new_cell   = ram_rdata | low_onehot;
    assign full_after = ((new_cell & vmask) == vmask);

    always_comb
    begin
        low_idx = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (freebits[i])
            begin
                low_idx = 5'(i);
            end
        end
    end

    // free: one page's cell and bit
    assign free_cell_hw = HW'(op_reg.first[14:5]);
    assign free_cell    = AW'(op_reg.first[14:5]);
    assign free_bit     = 32'd1 << op_reg.first[4:0];

    // area: the part of the run that falls in the current cell
    assign cur_cell  = AW'(cur_reg[15:5]);
    assign lo        = cur_reg[4:0];
    assign rem       = op_reg.last - cur_reg;
    assign room      = 6'd32 - {1'b0, lo};
    assign hi        = (rem < {10'd0, room}) ? ({1'b0, lo} + rem[5:0]) : 6'd32;
    assign upper     = hi[5] ? '1 : ((32'd1 << hi[4:0]) - 32'd1);
    assign lower     = (32'd1 << lo) - 32'd1;
    assign step_mask = upper & ~lower;
    assign cur_step  = cur_reg + {10'd0, hi - {1'b0, lo}};

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        hint_next   = hint_reg;
        scan_next   = scan_reg;
        cur_next    = cur_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        unique case (state_reg)
            pba_pkg::BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(NUM_CELLS - 1))
                begin
                    state_next = pba_pkg::BK_IDLE;
                end
            end
            pba_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop     = 1'b1;
                    op_next = head_op;
                    unique case (head_op.kind)
                        pba_pkg::OP_REPORT:
                        begin
                            done_next              = 1'b1;
                            result_next.alloc_page = '0;
                            result_next.status     = head_op.status;
                        end
                        pba_pkg::OP_ALLOC:
                        begin
                            scan_next  = hint_reg;
                            state_next = pba_pkg::BK_ALLOC_RD;
                        end
                        pba_pkg::OP_FREE:
                        begin
                            state_next = pba_pkg::BK_FREE_RD;
                        end
                        pba_pkg::OP_AREA:
                        begin
                            cur_next   = {1'b0, head_op.first};
                            state_next = pba_pkg::BK_AREA_STEP;
                        end
                    endcase
                end
            end
            pba_pkg::BK_ALLOC_RD:
            begin
                if (scan_reg >= cells)
                begin
                    done_next              = 1'b1;
                    result_next.alloc_page = '0;
                    result_next.status     = pba_pkg::ST_NONE;
                    state_next             = pba_pkg::BK_IDLE;
                end
                else
                begin
                    ram_raddr  = AW'(scan_reg);
                    state_next = pba_pkg::BK_ALLOC_CHK;
                end
            end
            pba_pkg::BK_ALLOC_CHK:
            begin
                if (freebits != 32'd0)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = AW'(scan_reg);
                    ram_wdata              = new_cell;
                    hint_next              = full_after ? (scan_reg + 1'b1) : scan_reg;
                    done_next              = 1'b1;
                    result_next.alloc_page = 15'({scan_reg, low_idx});
                    result_next.status     = pba_pkg::ST_DONE;
                    state_next             = pba_pkg::BK_IDLE;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = pba_pkg::BK_ALLOC_RD;
                end
            end
            pba_pkg::BK_FREE_RD:
            begin
                ram_raddr  = free_cell;
                state_next = pba_pkg::BK_FREE_WR;
            end
            pba_pkg::BK_FREE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = free_cell;
                ram_wdata = ram_rdata & ~free_bit;
                if (free_cell_hw < hint_reg)
                begin
                    hint_next = free_cell_hw;
                end
                done_next              = 1'b1;
                result_next.alloc_page = '0;
                result_next.status     = op_reg.status;
                state_next             = pba_pkg::BK_IDLE;
            end
            pba_pkg::BK_AREA_STEP:
            begin
                if (step_mask == '1)
                begin
                    // whole cell: write without reading
                    ram_we    = 1'b1;
                    ram_waddr = cur_cell;
                    ram_wdata = op_reg.make_free ? '0 : '1;
                    cur_next  = cur_step;
                    if (cur_step == op_reg.last)
                    begin
                        done_next              = 1'b1;
                        result_next.alloc_page = '0;
                        result_next.status     = op_reg.status;
                        state_next             = pba_pkg::BK_IDLE;
                    end
                end
                else
                begin
                    ram_raddr  = cur_cell;
                    state_next = pba_pkg::BK_AREA_WR;
                end
            end
            pba_pkg::BK_AREA_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_cell;
                ram_wdata = op_reg.make_free ? (ram_rdata & ~step_mask)
                                             : (ram_rdata | step_mask);
                cur_next  = cur_step;
                if (cur_step == op_reg.last)
                begin
                    done_next              = 1'b1;
                    result_next.alloc_page = '0;
                    result_next.status     = op_reg.status;
                    state_next             = pba_pkg::BK_IDLE;
                end
                else
                begin
                    state_next = pba_pkg::BK_AREA_STEP;
                end
            end
            default:
            begin
                state_next = pba_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pba_pkg::BK_CLEAR;
            hint_reg  <= HW'(START_CELL);
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        scan_reg   <= scan_next;
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    assign clearing = (state_reg == pba_pkg::BK_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

endmodule

[rtl/page_bitmap_allocator.sv]
// page_bitmap_allocator: top level of the bitmap page-frame allocator
// depends on pba_pkg, pba_front, pba_queue, pba_back (and pba_ram below it)
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+----------------------------
//  command   | start in, busy out             | request (pba_pkg::request_t)
//  result    | done out, one-cycle strobe     | result (pba_pkg::result_t)
//  config    | cfg_valid in, cfg_ready out    | cfg_data (total_pages)
//
// a command transfers at a clock edge with start high and busy low; every
//   command gives exactly one result, in command order
// commands settled up front (range errors, empty area, unused code) report from
//   the idle state; free reads its cell, then writes it; allocate scans from the
//   hint one cell at a time, each cell costing one ram read and one check; area
//   writes a whole cell without reading and does read-modify-write on a partly
//   covered cell (on the single ram port pair)
// after reset a clearing pass writes every cell reserved, one cell a cycle,
//   with busy high; config writes are taken during it
// the two-entry queue lets up to two commands wait while the sequencer works;
//   busy rises when it is full. the receiver cannot stall: done lasts one cycle
module page_bitmap_allocator #(
    parameter int NUM_CELLS  = 1024,
    parameter int START_CELL = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pba_pkg::request_t request,
    output logic              done,
    output pba_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    // front to queue
    logic               push;
    pba_pkg::op_t       push_op;

    // queue to back
    pba_pkg::op_t       head_op;
    pba_pkg::q_status_t q_status;
    logic               pop;

    // back status
    logic               clearing;

    // config register is a plain register write, always taken
    assign cfg_ready = 1'b1;

    // hold off commands during the clearing pass and while the queue is full
    assign busy = clearing || q_status.full;

    // front: page total register, range checks, area clipping
    pba_front #(
        .NUM_CELLS (NUM_CELLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .push      (push),
        .op        (push_op)
    );

    // decoupling queue
    pba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    // back: bitmap ram, search hint, command sequencer, result register
    pba_back #(
        .NUM_CELLS  (NUM_CELLS),
        .START_CELL (START_CELL)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_op  (head_op),
        .empty    (q_status.empty),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

[rtl/pba_checker.sv]
// pba_checker: port-level assertions for the page bitmap allocator, bound to the top
// depends on pba_pkg and page_bitmap_allocator_macros.svh
`include "page_bitmap_allocator_macros.svh"

module pba_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input pba_pkg::request_t request,
    input logic              done,
    input pba_pkg::result_t  result,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [15:0]       cfg_data
);

    // a page number comes only with a successful grant
    `PBA_ASSERT_IMPLY(a_page_only_on_grant, clk, rst_n, done && (result.alloc_page != 15'd0), result.status == pba_pkg::ST_DONE)

    // first cycle out of reset: clearing pass holds commands off, no result yet
    `PBA_ASSERT(a_clear_after_reset, clk, rst_n, $past(!rst_n) |-> (busy && !done))

    // register writes are never held off
    `PBA_ASSERT_IMPLY(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready)

    // failed allocate and range errors never report a page
    `PBA_ASSERT_IMPLY(a_fail_no_page, clk, rst_n, done && ((result.status == pba_pkg::ST_NONE) || (result.status == pba_pkg::ST_RANGE)), result.alloc_page == 15'd0)

endmodule

bind page_bitmap_allocator pba_checker u_checker (.*);

[bench/page_bitmap_allocator_tb.sv]
// page_bitmap_allocator_tb: self-checking bench for the page bitmap allocator
// keeps its own copy of the page map, hint and page total and checks every result
// depends on pba_pkg and page_bitmap_allocator from the rtl folder
module page_bitmap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int NUM_CELLS     = 1024;
    localparam int START_CELL    = 8;
    localparam int MAX_PAGES     = NUM_CELLS * CELL_BITS;
    // random page numbers mostly stay in a low window so allocate scans stay short
    localparam int WINDOW        = 2048;
    // cycles allowed after the last result before touching the page total or ending
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PHASES    = 11;

    // ------------------------------------------------------------------
    // page ledger: tracks the page map and checks results in command order
    // ------------------------------------------------------------------
    class page_ledger;
        bit [31:0]   page_map [NUM_CELLS];
        int unsigned search_hint;
        bit [15:0]   total_pages;
        result_t     awaited_results [$];
        int          errors;
        int          outcomes_seen;

        function void reset_state();
            foreach (page_map[i])
                page_map[i] = '1;
            search_hint = START_CELL;
            total_pages = TOTAL_PAGES_RST;
            awaited_results.delete();
            errors = 0;
            outcomes_seen = 0;
        endfunction

        function void set_total_pages(bit [15:0] value);
            total_pages = value;
        endfunction

        function int unsigned page_limit();
            return (total_pages < MAX_PAGES) ? total_pages : MAX_PAGES;
        endfunction

        // pages of one cell that lie below the page limit
        function bit [31:0] usable_bits(int unsigned cidx, int unsigned lim);
            int unsigned base;
            base = cidx * CELL_BITS;
            if (base >= lim)
                return '0;
            if (lim - base >= CELL_BITS)
                return '1;
            return (32'd1 << (lim - base)) - 32'd1;
        endfunction

        // grant the lowest free page at or above the hint, or report none
        function result_t grant_page();
            result_t     res;
            int unsigned lim, cells, pos;
            bit [31:0]   usable, open_bits;
            lim = page_limit();
            cells = (lim + CELL_BITS - 1) >> CELL_SHIFT;
            res.alloc_page = '0;
            res.status = ST_NONE;
            for (int unsigned cidx = search_hint; cidx < cells; cidx++)
            begin
                usable = usable_bits(cidx, lim);
                open_bits = ~page_map[cidx] & usable;
                if (open_bits != '0)
                begin
                    pos = 0;
                    while (!open_bits[pos])
                        pos++;
                    page_map[cidx][pos] = 1'b1;
                    // hint moves on only once the cell has no usable page left
                    search_hint = ((page_map[cidx] & usable) == usable) ? cidx + 1 : cidx;
                    res.alloc_page = 15'(cidx * CELL_BITS + pos);
                    res.status = ST_DONE;
                    return res;
                end
            end
            return res;
        endfunction

        function logic [1:0] release_page(int unsigned page);
            if (page >= page_limit())
                return ST_RANGE;
            page_map[page >> CELL_SHIFT][page % CELL_BITS] = 1'b0;
            if ((page >> CELL_SHIFT) < search_hint)
                search_hint = page >> CELL_SHIFT;
            return ST_DONE;
        endfunction

        // mark a run of pages, cut at the page limit; the hint is left alone
        function logic [1:0] mark_area(int unsigned first_page, int unsigned count,
                                       bit make_free);
            int unsigned lim, stop_page;
            logic [1:0]  st;
            lim = page_limit();
            st = ST_DONE;
            if (first_page >= lim)
                return ST_RANGE;
            if (count > lim - first_page)
            begin
                count = lim - first_page;
                st = ST_CLIP;
            end
            stop_page = first_page + count;
            for (int unsigned p = first_page; p < stop_page; p++)
                page_map[p >> CELL_SHIFT][p % CELL_BITS] = !make_free;
            return st;
        endfunction

        // one command transfer: work out its result and queue it
        function void note_command(request_t req);
            result_t res;
            res.alloc_page = '0;
            res.status = ST_DONE;
            case (req.cmd)
                CMD_ALLOC: res = grant_page();
                CMD_FREE:  res.status = release_page(req.page_index);
                CMD_AREA:  res.status = mark_area(req.page_index, req.page_count,
                                                  req.area_free);
                default:   res.status = ST_DONE;
            endcase
            awaited_results.push_back(res);
        endfunction

        function void check_outcome(result_t got);
            result_t want;
            outcomes_seen++;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d with nothing outstanding: page %0d status %0d",
                             outcomes_seen, got.alloc_page, got.status);
                return;
            end
            want = awaited_results.pop_front();
            if (got.alloc_page !== want.alloc_page || got.status !== want.status)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d: expected page %0d status %0d, got page %0d status %0d",
                             outcomes_seen, want.alloc_page, want.status,
                             got.alloc_page, got.status);
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, dut and signals
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    page_ledger  ledger;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    page_bitmap_allocator #(
        .NUM_CELLS  (NUM_CELLS),
        .START_CELL (START_CELL)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // monitor: values read right after the edge are the ones the edge used,
    // since the dut updates its outputs later in the same time step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a result never belongs to the command taken at the same edge
            if (done)
                ledger.check_outcome(result);
            if (start && !busy)
                ledger.note_command(request);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic request_t make_request(logic [1:0] cmd, int unsigned idx,
                                              int unsigned cnt, bit make_free);
        request_t req;
        req.cmd = cmd;
        req.page_index = 15'(idx);
        req.page_count = 16'(cnt);
        req.area_free = make_free;
        return req;
    endfunction

    // mostly commands that land inside the live window, some noise across the
    // whole field ranges so every field bit toggles
    function automatic request_t random_request(int unsigned lim);
        request_t    req;
        int unsigned span;
        int          pick;
        span = (lim > WINDOW) ? WINDOW : lim;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            req.cmd = CMD_ALLOC;
        else if (pick < 65)
            req.cmd = CMD_FREE;
        else if (pick < 95)
            req.cmd = CMD_AREA;
        else
            req.cmd = CMD_NONE;
        if (span == 0 || $urandom_range(0, 9) == 0)
            req.page_index = 15'($urandom_range(0, 32767));
        else
            req.page_index = 15'($urandom_range(0, span - 1));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            req.page_count = '0;
        else if (pick < 3)
            req.page_count = 16'($urandom_range(0, 65535));
        else if (pick < 14)
            req.page_count = 16'($urandom_range(1, 40));
        else
            req.page_count = 16'($urandom_range(1, (span > 1) ? span : 1));
        req.area_free = ($urandom_range(0, 99) < 65);
        return req;
    endfunction

    // hold start until the command transfers; start stays high on return
    task automatic send_request(request_t req);
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random commands in bursts with random gaps, start low on return
    task automatic send_random(int count);
        int left, burst, gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                send_request(random_request(ledger.page_limit()));
                left--;
            end
            // about a quarter of the bursts run straight into the next one
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0 || left == 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // wait for every outstanding result, then let the sequencer settle;
    // first an edge, so the command taken at the last edge is on the ledger
    task automatic drain();
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_total_pages(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.set_total_pages(value);
    endtask

    // fixed checks at the reset page total, then a short pass at 33 pages
    task automatic run_directed();
        // fully reserved map: allocate scans every cell from the hint on and finds nothing
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        // free below the hint pulls the hint down, allocate fills the cell
        send_request(make_request(CMD_FREE, 0, 0, 1'b0));
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        // short run inside one cell
        send_request(make_request(CMD_AREA, 40, 10, 1'b1));
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        // run across cells with partial ends; pages under the hint stay unused
        send_request(make_request(CMD_AREA, 5, 100, 1'b1));
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        send_request(make_request(CMD_FREE, 3, 0, 1'b0));
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        // run ending exactly at the limit, then one cut at the limit
        send_request(make_request(CMD_AREA, MAX_PAGES - 8, 8, 1'b1));
        send_request(make_request(CMD_AREA, 32767, 16'hFFFF, 1'b1));
        // freeing a page that is already free
        send_request(make_request(CMD_FREE, 32767, 0, 1'b0));
        // empty run and unused command code
        send_request(make_request(CMD_AREA, 100, 0, 1'b0));
        send_request(make_request(CMD_NONE, 32767, 16'hFFFF, 1'b1));
        // reserve everything, then free two cells for the short page total
        send_request(make_request(CMD_AREA, 0, MAX_PAGES, 1'b0));
        send_request(make_request(CMD_AREA, 0, 64, 1'b1));
        start <= 1'b0;
        drain();

        // 33 pages: free bits above the limit must never be granted
        write_total_pages(16'd33);
        send_request(make_request(CMD_AREA, 0, 32, 1'b0));
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        send_request(make_request(CMD_ALLOC, 0, 0, 1'b0));
        send_request(make_request(CMD_FREE, 33, 0, 1'b0));
        send_request(make_request(CMD_AREA, 33, 1, 1'b1));
        send_request(make_request(CMD_AREA, 0, 40, 1'b1));
        start <= 1'b0;
        drain();
    endtask

    // one page total: open a low window, then random traffic
    task automatic run_phase(logic [15:0] total, int count);
        int unsigned lim;
        write_total_pages(total);
        lim = ledger.page_limit();
        if (lim > 0)
        begin
            send_request(make_request(CMD_AREA, 0, (lim > WINDOW) ? WINDOW : lim, 1'b1));
            start <= 1'b0;
            @(posedge clk);
        end
        send_random(count);
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [15:0] phase_total [NUM_PHASES];
        ledger = new();
        ledger.reset_state();
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        // extremes, cell edges around 32 pages, and a few odd sizes
        phase_total = '{16'hFFFF, 16'd0, 16'd1, 16'd31, 16'd32, 16'd33, 16'd1000,
                        16'd4097, 16'($urandom_range(34, 3000)),
                        16'($urandom_range(0, 65535)), 16'd32768};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the clearing pass takes config writes; commands wait on busy
        write_total_pages(TOTAL_PAGES_RST);
        run_directed();

        foreach (phase_total[i])
            run_phase(phase_total[i], (phase_total[i] < 2) ? 50 : 125);

        drain();
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("page_bitmap_allocator: match");
        else
            $display("page_bitmap_allocator: mismatch");
        $finish;
    end

    // watchdog: many times the slowest legal run, where every allocate walks
    // all cells after the clearing pass
    initial
    begin
        #250_000_000;
        $display("page_bitmap_allocator: mismatch");
        $finish;
    end

endmodule
